>>> rtl/core/pfe_pkg.sv
// Package for the postfix expression evaluator: payload structs, character codes,
// microcode step and control word types, and the microcode ROM.
// No dependencies; every other file of the block uses it by scoped names.
package pfe_pkg;

   localparam int unsigned STACK_DEPTH_DEF = 32;
   localparam int unsigned WORD_W          = 32;
   localparam int unsigned DEPTH_OUT_W     = 6;

   // Characters that select an operation; anything else is a literal.
   localparam logic [7:0] OP_ADD = 8'h2B;   // '+'
   localparam logic [7:0] OP_SUB = 8'h2D;   // '-'
   localparam logic [7:0] OP_MUL = 8'h2A;   // '*'
   localparam logic [7:0] OP_DIV = 8'h2F;   // '/'

   localparam logic [WORD_W-1:0] LIT_BIAS  = WORD_W'(48);
   localparam logic [WORD_W-1:0] EMPTY_VAL = '1;   // value of a pop from an empty stack

   localparam int unsigned        DIV_STEPS = WORD_W;
   localparam int unsigned        DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   typedef struct packed {
      logic [7:0] symbol;
      logic       end_of_expr;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]      answer;
      logic                          underflow_seen;
      logic                          overflow_seen;
      logic                          zero_divisor_seen;
      logic [DEPTH_OUT_W-1:0]        depth_left;
   } rsp_type;

   // Microcode steps, in program order.
   typedef enum logic [3:0] {
      S_IDLE     = 4'd0,
      S_DECODE   = 4'd1,
      S_POPA_RD  = 4'd2,
      S_POPA_LD  = 4'd3,
      S_POPB_RD  = 4'd4,
      S_POPB_LD  = 4'd5,
      S_EXEC     = 4'd6,
      S_DIV      = 4'd7,
      S_DIV_FIX  = 4'd8,
      S_PUSH     = 4'd9,
      S_FIN_RD   = 4'd10,
      S_FIN_EMIT = 4'd11
   } step_type;

   // Jump conditions: when the condition holds, go to target, else fall through.
   typedef enum logic [2:0] {
      C_NEXT,
      C_GOTO,
      C_LITERAL,
      C_NOT_DIV,
      C_DIV_BUSY,
      C_NOT_LAST
   } cond_type;

   typedef struct packed {
      logic     take;       // accept an input transaction, hold until one arrives
      logic     ld_lit;     // result <= symbol - 48
      logic     pop;        // pop issue: read top, update count
      logic     ld_a;
      logic     ld_b;
      logic     exec;       // add, subtract, multiply, or divider setup
      logic     div_step;
      logic     div_fix;
      logic     push;
      logic     emit;       // load the response register, hold while it is full and not drained
      cond_type cond;
      step_type target;
   } ucode_type;

   function automatic ucode_type pfe_ucode(step_type step);
      ucode_type w;
      w = '{default: '0, cond: C_NEXT, target: S_IDLE};
      case (step)
         S_IDLE:     w.take = 1'b1;
         S_DECODE: begin
            w.ld_lit = 1'b1;
            w.cond   = C_LITERAL;
            w.target = S_PUSH;
         end
         S_POPA_RD:  w.pop  = 1'b1;
         S_POPA_LD:  w.ld_a = 1'b1;
         S_POPB_RD:  w.pop  = 1'b1;
         S_POPB_LD:  w.ld_b = 1'b1;
         S_EXEC: begin
            w.exec   = 1'b1;
            w.cond   = C_NOT_DIV;
            w.target = S_PUSH;
         end
         S_DIV: begin
            w.div_step = 1'b1;
            w.cond     = C_DIV_BUSY;
            w.target   = S_DIV;
         end
         S_DIV_FIX:  w.div_fix = 1'b1;
         S_PUSH: begin
            w.push   = 1'b1;
            w.cond   = C_NOT_LAST;
            w.target = S_IDLE;
         end
         S_FIN_RD:   w.pop = 1'b1;
         S_FIN_EMIT: begin
            w.emit   = 1'b1;
            w.cond   = C_GOTO;
            w.target = S_IDLE;
         end
         default: begin
            w.cond   = C_GOTO;
            w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

>>> rtl/core/pfe_if.sv
// Valid/ready channel interfaces for the postfix expression evaluator.
// Depends on pfe_pkg for the request and response payload structs.
interface pfe_req_if;
   logic             valid;
   logic             ready;
   pfe_pkg::req_type payload;

   modport source  (output valid, output payload, input ready);
   modport sink    (input valid, input payload, output ready);
   modport monitor (input valid, input payload, input ready);
endinterface

interface pfe_rsp_if;
   logic             valid;
   logic             ready;
   pfe_pkg::rsp_type payload;

   modport source  (output valid, output payload, input ready);
   modport sink    (input valid, input payload, output ready);
   modport monitor (input valid, input payload, input ready);
endinterface

>>> rtl/core/postfix_expression_evaluator.sv
// Postfix evaluator, one character per transaction. Steps after accept: literal: decode, push;
// '+' '-' '*': decode, pop and load each operand, execute, push; '/' adds one division step
// per quotient bit and a sign fix before the push (a zero divisor goes straight to the push);
// a final character adds a pop and an emit that holds while the response register is full.
// Synchronous active-high reset empties the stack, clears the error flags and the response
// valid flag and returns the sequencer to idle; stack words are not cleared. Depends on pfe_pkg and pfe_if.
module postfix_expression_evaluator #(
   parameter int unsigned STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pfe_req_if.sink    req_if,
   pfe_rsp_if.source  rsp_if
);

   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned W  = pfe_pkg::WORD_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

   // Sequencer
   pfe_pkg::step_type  pc_ff, pc_in;
   pfe_pkg::ucode_type cw;
   logic               stall;
   logic               fire;
   logic               cond_hit;

   // Datapath
   logic [7:0]         sym_ff;
   logic               last_ff;
   logic [W-1:0]       a_ff, b_ff, r_ff;
   logic [W-1:0]       rem_ff, quo_ff, den_ff;
   logic               neg_ff;
   logic [pfe_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [W:0]         rem_sh, diff;
   logic               is_oper;
   logic               div_zero;
   logic [W-1:0]       pop_val;

   // Stack
   logic [W-1:0]       stack_mem [STACK_DEPTH];
   logic [W-1:0]       mem_q_ff;
   logic               pop_empty_ff;
   logic [CW-1:0]      count_ff;
   logic               empty, full;
   logic [CW-1:0]      count_dec;
   logic [AW-1:0]      rd_addr, wr_addr;

   // Sticky error flags
   logic               under_ff, over_ff, zdiv_ff;

   // Response register
   logic               rsp_valid_ff;
   pfe_pkg::rsp_type   rsp_pl_ff;

   assign is_oper  = (sym_ff == pfe_pkg::OP_ADD) || (sym_ff == pfe_pkg::OP_SUB) ||
                     (sym_ff == pfe_pkg::OP_MUL) || (sym_ff == pfe_pkg::OP_DIV);
   assign div_zero = (a_ff == '0);
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == FULL_COUNT);
   assign count_dec = count_ff - CW'(1);
   assign rd_addr  = count_dec[AW-1:0];
   assign wr_addr  = count_ff[AW-1:0];
   assign pop_val  = pop_empty_ff ? pfe_pkg::EMPTY_VAL : mem_q_ff;

   // One restoring-division step: shift in the next dividend bit, trial subtract.
   assign rem_sh = {rem_ff, quo_ff[W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};

   // Fetch the control word, decide stall and next step.
   always_comb begin
      cw    = pfe_pkg::pfe_ucode(pc_ff);
      // Hold in idle until a transaction arrives; hold the emit step while the
      // response register is occupied and not being drained.
      stall = (cw.take && !req_if.valid) || (cw.emit && rsp_valid_ff && !rsp_if.ready);
      fire  = !stall;
      case (cw.cond)
         pfe_pkg::C_NEXT:     cond_hit = 1'b0;
         pfe_pkg::C_GOTO:     cond_hit = 1'b1;
         pfe_pkg::C_LITERAL:  cond_hit = !is_oper;
         pfe_pkg::C_NOT_DIV:  cond_hit = (sym_ff != pfe_pkg::OP_DIV) || div_zero;
         pfe_pkg::C_DIV_BUSY: cond_hit = (div_cnt_ff != '0);
         pfe_pkg::C_NOT_LAST: cond_hit = !last_ff;
         default:             cond_hit = 1'b1;
      endcase
      if (stall) begin
         pc_in = pc_ff;
      end else if (cond_hit) begin
         pc_in = cw.target;
      end else begin
         pc_in = pfe_pkg::step_type'(pc_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= pfe_pkg::S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign req_if.ready = cw.take;

   // Stack count and sticky flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         under_ff <= 1'b0;
         over_ff  <= 1'b0;
         zdiv_ff  <= 1'b0;
      end else if (fire) begin
         if (cw.pop) begin
            if (empty) begin
               under_ff <= 1'b1;
            end else begin
               count_ff <= count_dec;
            end
         end
         if (cw.push) begin
            if (full) begin
               over_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + CW'(1);
            end
         end
         if (cw.exec && (sym_ff == pfe_pkg::OP_DIV) && div_zero) begin
            zdiv_ff <= 1'b1;
         end
         // Flags are per expression: drop them once reported.
         if (cw.emit) begin
            under_ff <= 1'b0;
            over_ff  <= 1'b0;
            zdiv_ff  <= 1'b0;
         end
      end
   end

   // Stack memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (fire && cw.pop) begin
         pop_empty_ff <= empty;
         if (!empty) begin
            mem_q_ff <= stack_mem[rd_addr];
         end
      end
      if (fire && cw.push && !full) begin
         stack_mem[wr_addr] <= r_ff;
      end
   end

   // Operand, ALU and divider registers.
   always_ff @(posedge clock) begin
      if (fire && cw.take) begin
         sym_ff  <= req_if.payload.symbol;
         last_ff <= req_if.payload.end_of_expr;
      end
      if (fire && cw.ld_lit) begin
         r_ff <= W'(sym_ff) - pfe_pkg::LIT_BIAS;
      end
      if (fire && cw.ld_a) begin
         a_ff <= pop_val;
      end
      if (fire && cw.ld_b) begin
         b_ff <= pop_val;
      end
      if (fire && cw.exec) begin
         case (sym_ff)
            pfe_pkg::OP_ADD: r_ff <= b_ff + a_ff;
            pfe_pkg::OP_SUB: r_ff <= b_ff - a_ff;
            pfe_pkg::OP_MUL: r_ff <= b_ff * a_ff;
            pfe_pkg::OP_DIV: begin
               // Zero divisor pushes 0; otherwise divide magnitudes, fix sign later.
               r_ff       <= '0;
               rem_ff     <= '0;
               quo_ff     <= b_ff[W-1] ? (W'(0) - b_ff) : b_ff;
               den_ff     <= a_ff[W-1] ? (W'(0) - a_ff) : a_ff;
               neg_ff     <= b_ff[W-1] ^ a_ff[W-1];
               div_cnt_ff <= pfe_pkg::DIV_LAST;
            end
            default: r_ff <= r_ff;
         endcase
      end
      if (fire && cw.div_step) begin
         rem_ff     <= diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
         quo_ff     <= {quo_ff[W-2:0], ~diff[W]};
         div_cnt_ff <= div_cnt_ff - pfe_pkg::DIV_CNT_W'(1);
      end
      if (fire && cw.div_fix) begin
         r_ff <= neg_ff ? (W'(0) - quo_ff) : quo_ff;
      end
   end

   // Response register: parts the sequencer from the consumer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && cw.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && cw.emit) begin
         rsp_pl_ff.answer            <= pop_val;
         rsp_pl_ff.underflow_seen    <= under_ff;
         rsp_pl_ff.overflow_seen     <= over_ff;
         rsp_pl_ff.zero_divisor_seen <= zdiv_ff;
         rsp_pl_ff.depth_left        <= pfe_pkg::DEPTH_OUT_W'(count_ff);
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_pl_ff;

endmodule

>>> rtl/core/pfe_checker.sv
// Port-level checker for the postfix expression evaluator, bound to its top level.
// Depends on pfe_pkg; the bind below wires it to the top level's channel signals.
module pfe_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_end_of_expr,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pfe_pkg::rsp_type rsp_payload
);

   logic [1:0] pend_ff;
   logic       last_acc;
   logic       rsp_acc;

   assign last_acc = req_valid && req_ready && req_end_of_expr;
   assign rsp_acc  = rsp_valid && rsp_ready;

   // Count final characters accepted whose response is not yet taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else if (last_acc && !rsp_acc) begin
         pend_ff <= pend_ff + 2'd1;
      end else if (rsp_acc && !last_acc) begin
         pend_ff <= pend_ff - 2'd1;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_rsp_caused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without a final character");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two expressions outstanding");

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_end_of_expr (req_if.payload.end_of_expr),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_payload     (rsp_if.payload)
);
